// ----- rtl/core/dmdt_pkg.sv -----
// ----------------------------------------------------------------------------
// dmdt_pkg
// Shared types and constants for the dual mode down timer channel.
// ----------------------------------------------------------------------------
package dmdt_pkg;

    localparam int FUNC_W = 2;
    localparam int OFF_W  = 3;
    localparam int DATA_W = 32;
    localparam int CTRL_W = 8;
    localparam int PRE_W  = 8;

    // Transaction kinds
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // Register word offsets
    localparam logic [OFF_W-1:0] OFF_LOAD   = 3'd0;
    localparam logic [OFF_W-1:0] OFF_VALUE  = 3'd1;
    localparam logic [OFF_W-1:0] OFF_CTRL   = 3'd2;
    localparam logic [OFF_W-1:0] OFF_CLR    = 3'd3;
    localparam logic [OFF_W-1:0] OFF_RIS    = 3'd4;
    localparam logic [OFF_W-1:0] OFF_MIS    = 3'd5;
    localparam logic [OFF_W-1:0] OFF_BGLOAD = 3'd6;

    // Control bit positions
    localparam int CTL_EN_BIT  = 7;
    localparam int CTL_MP_BIT  = 6;
    localparam int CTL_IEN_BIT = 5;
    localparam int CTL_PRE_HI  = 3;
    localparam int CTL_PRE_LO  = 2;
    localparam int CTL_S32_BIT = 1;
    localparam int CTL_1S_BIT  = 0;

    localparam logic [CTRL_W-1:0] CTL_KEEP  = 8'hEF;
    localparam logic [CTRL_W-1:0] CTL_RESET = 8'h20;

    // Prescale codes
    localparam logic [1:0] PRE_DIV16  = 2'd1;
    localparam logic [1:0] PRE_DIV256 = 2'd2;

    localparam logic [PRE_W-1:0] PRE_LAST16  = 8'd15;
    localparam logic [PRE_W-1:0] PRE_LAST256 = 8'd255;

    localparam logic [DATA_W-1:0] MASK16 = 32'h0000_FFFF;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [OFF_W-1:0]  reg_offset;
        logic [DATA_W-1:0] write_data;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_out;
    } t_rsp;

endpackage

// ----- rtl/core/dual_mode_down_timer.sv -----
// An accepted transaction is registered in the input stage, its result in the
// output stage; an output stall holds both. Throughput: one transaction per
// cycle unless the output stalls, set by one pass through the register-file logic.
// Reset (sync, active low): load 0, value 0xFFFFFFFF, control 0x20,
// raw interrupt 0, prescaler 0; both pipeline stages empty.
// ----------------------------------------------------------------------------
// dual_mode_down_timer
// One down-counting timer channel driven by tick / write / read transactions.
// ----------------------------------------------------------------------------
module dual_mode_down_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] write_data
    input  logic [4:0]  i_s_tuser,   // [1:0] func, [4:2] reg_offset
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // [31:0] read_data, [32] irq_out, [39:33] zero
);
    import dmdt_pkg::*;

    logic   r_in_valid;
    t_req   r_in;
    logic   r_out_valid;
    t_rsp   r_out;
    logic   advance;
    t_rsp   rsp;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    dmdt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_req   (r_in),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.func       <= i_s_tuser[FUNC_W-1:0];
            r_in.reg_offset <= i_s_tuser[FUNC_W+OFF_W-1:FUNC_W];
            r_in.write_data <= i_s_tdata;
        end
        if (advance) begin
            r_out <= rsp;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out.irq_out, r_out.read_data};

endmodule

// ----- rtl/core/dmdt_regs.sv -----
// ----------------------------------------------------------------------------
// dmdt_regs
// Timer register file and counter: applies one transaction per enabled cycle.
// ----------------------------------------------------------------------------
module dmdt_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  dmdt_pkg::t_req i_req,
    output dmdt_pkg::t_rsp o_rsp
);
    import dmdt_pkg::*;

    logic [DATA_W-1:0] r_load, n_load;
    logic [DATA_W-1:0] r_count, n_count;
    logic [CTRL_W-1:0] r_ctrl, n_ctrl;
    logic              r_raw, n_raw;
    logic [PRE_W-1:0]  r_pre, n_pre;

    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] cur;
    logic [DATA_W-1:0] dec_next;
    logic              dec_hold;
    logic              pre_wrap;
    logic [DATA_W-1:0] rdata;

    // Next counter value for one decrement step
    always_comb begin
        mask     = r_ctrl[CTL_S32_BIT] ? '1 : MASK16;
        cur      = r_count & mask;
        dec_hold = 1'b0;
        dec_next = r_count;
        if (cur == '0) begin
            if (r_ctrl[CTL_1S_BIT]) begin
                dec_hold = 1'b1;
            end else if (r_ctrl[CTL_MP_BIT]) begin
                dec_next = r_load & mask;
            end else begin
                dec_next = mask;
            end
        end else begin
            dec_next = (cur - 1'b1) & mask;
        end
    end

    always_comb begin
        unique case (r_ctrl[CTL_PRE_HI:CTL_PRE_LO])
            PRE_DIV16:  pre_wrap = (r_pre >= PRE_LAST16);
            PRE_DIV256: pre_wrap = (r_pre >= PRE_LAST256);
            default:    pre_wrap = 1'b1;
        endcase
    end

    always_comb begin
        n_load  = r_load;
        n_count = r_count;
        n_ctrl  = r_ctrl;
        n_raw   = r_raw;
        n_pre   = r_pre;
        rdata   = '0;
        unique case (i_req.func)
            FUNC_TICK: begin
                if (r_ctrl[CTL_EN_BIT]) begin
                    if (pre_wrap) begin
                        n_pre = '0;
                        if (!dec_hold) begin
                            n_count = dec_next;
                            if (dec_next == '0) begin
                                n_raw = 1'b1;
                            end
                        end
                    end else begin
                        n_pre = r_pre + 1'b1;
                    end
                end
            end
            FUNC_WRITE: begin
                unique case (i_req.reg_offset)
                    OFF_LOAD: begin
                        n_load  = i_req.write_data;
                        n_count = i_req.write_data;
                        n_pre   = '0;
                    end
                    OFF_CTRL: begin
                        n_ctrl = i_req.write_data[CTRL_W-1:0] & CTL_KEEP;
                        n_pre  = '0;
                    end
                    OFF_CLR:    n_raw  = 1'b0;
                    OFF_BGLOAD: n_load = i_req.write_data;
                    default: ;  // read-only and unused offsets
                endcase
            end
            FUNC_READ: begin
                unique case (i_req.reg_offset)
                    OFF_LOAD:   rdata = r_load;
                    OFF_VALUE:  rdata = r_count;
                    OFF_CTRL:   rdata = {{(DATA_W-CTRL_W){1'b0}}, r_ctrl};
                    OFF_RIS:    rdata = {{(DATA_W-1){1'b0}}, r_raw};
                    OFF_MIS:    rdata = {{(DATA_W-1){1'b0}}, r_raw & r_ctrl[CTL_IEN_BIT]};
                    OFF_BGLOAD: rdata = r_load;
                    default:    rdata = '0;
                endcase
            end
            default: ;
        endcase
    end

    // Response reflects state after this transaction
    assign o_rsp.read_data = rdata;
    assign o_rsp.irq_out   = n_raw & n_ctrl[CTL_IEN_BIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load  <= '0;
            r_count <= '1;
            r_ctrl  <= CTL_RESET;
            r_raw   <= 1'b0;
            r_pre   <= '0;
        end else if (i_en) begin
            r_load  <= n_load;
            r_count <= n_count;
            r_ctrl  <= n_ctrl;
            r_raw   <= n_raw;
            r_pre   <= n_pre;
        end
    end

endmodule
